@@ src/sqe_pkg.sv @@
// Shared types and constants for the stack/queue engine.
// No dependencies; used by sqe_div and stack_queue_engine_core.
`default_nettype none

package sqe_pkg;

    // Word store geometry; DEPTH is kept a power of two so pointers wrap freely.
    localparam int DEPTH   = 256;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int WORD_W  = 32;
    localparam int ENTRY_W = 9;
    localparam int DIV_CNT_W = $clog2(WORD_W);

    typedef enum logic [2:0] {
        ACT_PUSH_TOP    = 3'd0,
        ACT_PUSH_BOTTOM = 3'd1,
        ACT_SWAP        = 3'd2,
        ACT_MOD         = 3'd3,
        ACT_NOP         = 3'd4,
        ACT_QUEUE_MODE  = 3'd5,
        ACT_STACK_MODE  = 3'd6
    } action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SHORT   = 2'd1,
        ST_DIVZERO = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SWAP_RD,
        S_SWAP_WR,
        S_MOD_RD,
        S_MOD_DIV,
        S_EMIT
    } fsm_t;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] remainder;
    } div_rsp_t;

endpackage

`default_nettype wire

@@ src/stack_queue_engine_core.sv @@
// Stack/queue engine top level: word store, control sequencer, result register.
// Depends on sqe_pkg and sqe_div.
//
//  channel | ports                                                  | direction
//  --------+--------------------------------------------------------+----------
//  input   | s_valid s_ready s_action s_value                       | in
//  result  | m_valid m_ready m_status m_top_word m_entry_count      | out
//          | m_queue_mode                                           |
//
// Push, nop and mode words go straight to emit; swap adds one store read and
// two writes through the single write port; mod waits on the 32 iterations
// of the remainder unit. Reset is synchronous: pointer, count and mode clear;
// the store itself is not cleared, only written entries are ever read.
// A finished result sits in the output register while the next word is
// taken; a stalled result register holds the sequencer in its emit step.
`default_nettype none

module stack_queue_engine_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_action,
    input  wire logic signed [31:0] s_value,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic signed [31:0] m_top_word,
    output logic [8:0]       m_entry_count,
    output logic             m_queue_mode
);

    localparam int PW = sqe_pkg::PTR_W;
    localparam int CW = sqe_pkg::CNT_W;
    localparam int WW = sqe_pkg::WORD_W;

    // word store
    logic [WW-1:0] mem [sqe_pkg::DEPTH];
    logic          we;
    logic [PW-1:0] waddr;
    logic [WW-1:0] wdata;
    logic [PW-1:0] raddr;
    logic [WW-1:0] rd_data_reg;

    sqe_pkg::fsm_t    state_reg, state_next;
    logic [PW-1:0]    ptr_reg, ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             mode_reg, mode_next;
    logic [WW-1:0]    top_reg, top_next;
    sqe_pkg::status_t status_reg, status_next;

    logic                   m_valid_reg, m_valid_next;
    sqe_pkg::status_t       m_status_reg, m_status_next;
    logic [WW-1:0]          m_top_reg, m_top_next;
    logic [sqe_pkg::ENTRY_W-1:0] m_cnt_reg, m_cnt_next;
    logic                   m_mode_reg, m_mode_next;

    sqe_pkg::div_req_t div_req;
    sqe_pkg::div_rsp_t div_rsp;

    logic accept;
    logic full;
    logic short_stack;
    logic out_free;

    sqe_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // second entry is always the one below the top
    assign raddr = ptr_reg + PW'(1);

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    assign s_ready     = (state_reg == sqe_pkg::S_IDLE);
    assign accept      = s_valid && s_ready;
    assign full        = (cnt_reg >= CW'(sqe_pkg::DEPTH));
    assign short_stack = (cnt_reg < CW'(2));
    assign out_free    = !m_valid_reg || m_ready;

    always_comb begin
        state_next  = state_reg;
        ptr_next    = ptr_reg;
        cnt_next    = cnt_reg;
        mode_next   = mode_reg;
        top_next    = top_reg;
        status_next = status_reg;
        we          = 1'b0;
        waddr       = ptr_reg;
        wdata       = top_reg;
        div_req.start    = 1'b0;
        div_req.dividend = rd_data_reg;
        div_req.divisor  = top_reg;

        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_top_next    = m_top_reg;
        m_cnt_next    = m_cnt_reg;
        m_mode_next   = m_mode_reg;

        case (state_reg)
            sqe_pkg::S_IDLE: begin
                if (accept) begin
                    status_next = sqe_pkg::ST_OK;
                    state_next  = sqe_pkg::S_EMIT;
                    case (sqe_pkg::action_t'(s_action))
                        sqe_pkg::ACT_PUSH_TOP: begin
                            if (full) begin
                                status_next = sqe_pkg::ST_FULL;
                            end else begin
                                ptr_next = ptr_reg - PW'(1);
                                we       = 1'b1;
                                waddr    = ptr_reg - PW'(1);
                                wdata    = s_value;
                                top_next = s_value;
                                cnt_next = cnt_reg + CW'(1);
                            end
                        end
                        sqe_pkg::ACT_PUSH_BOTTOM: begin
                            if (full) begin
                                status_next = sqe_pkg::ST_FULL;
                            end else begin
                                we    = 1'b1;
                                waddr = ptr_reg + cnt_reg[PW-1:0];
                                wdata = s_value;
                                if (cnt_reg == '0) begin
                                    top_next = s_value;
                                end
                                cnt_next = cnt_reg + CW'(1);
                            end
                        end
                        sqe_pkg::ACT_SWAP: begin
                            if (short_stack) begin
                                status_next = sqe_pkg::ST_SHORT;
                            end else begin
                                state_next = sqe_pkg::S_SWAP_RD;
                            end
                        end
                        sqe_pkg::ACT_MOD: begin
                            if (short_stack) begin
                                status_next = sqe_pkg::ST_SHORT;
                            end else if (top_reg == '0) begin
                                status_next = sqe_pkg::ST_DIVZERO;
                            end else begin
                                state_next = sqe_pkg::S_MOD_RD;
                            end
                        end
                        sqe_pkg::ACT_QUEUE_MODE: mode_next = 1'b1;
                        sqe_pkg::ACT_STACK_MODE: mode_next = 1'b0;
                        default: ;
                    endcase
                end
            end
            sqe_pkg::S_SWAP_RD: begin
                // old top goes down, second comes up
                we         = 1'b1;
                waddr      = raddr;
                wdata      = top_reg;
                top_next   = rd_data_reg;
                state_next = sqe_pkg::S_SWAP_WR;
            end
            sqe_pkg::S_SWAP_WR: begin
                we         = 1'b1;
                waddr      = ptr_reg;
                wdata      = top_reg;
                state_next = sqe_pkg::S_EMIT;
            end
            sqe_pkg::S_MOD_RD: begin
                div_req.start = 1'b1;
                state_next    = sqe_pkg::S_MOD_DIV;
            end
            sqe_pkg::S_MOD_DIV: begin
                if (div_rsp.done) begin
                    we         = 1'b1;
                    waddr      = raddr;
                    wdata      = div_rsp.remainder;
                    top_next   = div_rsp.remainder;
                    ptr_next   = raddr;
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = sqe_pkg::S_EMIT;
                end
            end
            sqe_pkg::S_EMIT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_top_next    = (cnt_reg == '0) ? '0 : top_reg;
                    m_cnt_next    = sqe_pkg::ENTRY_W'(cnt_reg);
                    m_mode_next   = mode_reg;
                    state_next    = sqe_pkg::S_IDLE;
                end
            end
            default: state_next = sqe_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sqe_pkg::S_IDLE;
        end else begin
            state_reg   <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg     <= '0;
            cnt_reg     <= '0;
            mode_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            ptr_reg     <= ptr_next;
            cnt_reg     <= cnt_next;
            mode_reg    <= mode_next;
            m_valid_reg <= m_valid_next;
        end
        top_reg      <= top_next;
        status_reg   <= status_next;
        m_status_reg <= m_status_next;
        m_top_reg    <= m_top_next;
        m_cnt_reg    <= m_cnt_next;
        m_mode_reg   <= m_mode_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_top_word    = m_top_reg;
    assign m_entry_count = m_cnt_reg;
    assign m_queue_mode  = m_mode_reg;

endmodule

`default_nettype wire

@@ src/sqe_div.sv @@
// Iterative signed remainder unit, one quotient bit per cycle.
// Depends on sqe_pkg for word width and request/response structs.
`default_nettype none

module sqe_div (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire sqe_pkg::div_req_t req,
    output sqe_pkg::div_rsp_t     rsp
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [sqe_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [sqe_pkg::WORD_W-1:0]    rem_reg, rem_next;
    logic [sqe_pkg::WORD_W-1:0]    quo_reg, quo_next;
    logic [sqe_pkg::WORD_W-1:0]    ub_reg, ub_next;
    logic                          neg_reg, neg_next;
    logic [sqe_pkg::WORD_W-1:0]    res_reg, res_next;
    logic [sqe_pkg::WORD_W:0]      trial;
    logic [sqe_pkg::WORD_W-1:0]    rem_step;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        ub_next   = ub_reg;
        neg_next  = neg_reg;
        res_next  = res_reg;

        trial    = {rem_reg, quo_reg[sqe_pkg::WORD_W-1]};
        rem_step = (trial >= {1'b0, ub_reg}) ? sqe_pkg::WORD_W'(trial - {1'b0, ub_reg})
                                             : trial[sqe_pkg::WORD_W-1:0];

        if (req.start) begin
            // take magnitudes; the remainder carries the dividend's sign
            neg_next  = req.dividend[sqe_pkg::WORD_W-1];
            quo_next  = req.dividend[sqe_pkg::WORD_W-1] ? (-req.dividend) : req.dividend;
            ub_next   = req.divisor[sqe_pkg::WORD_W-1] ? (-req.divisor) : req.divisor;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = rem_step;
            quo_next = {quo_reg[sqe_pkg::WORD_W-2:0], 1'b0};
            cnt_next = cnt_reg + sqe_pkg::DIV_CNT_W'(1);
            if (cnt_reg == sqe_pkg::DIV_CNT_W'(sqe_pkg::WORD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                res_next  = neg_reg ? (-rem_step) : rem_step;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        ub_reg  <= ub_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = res_reg;

endmodule

`default_nettype wire
